// ===== hdl/sf3_pkg.sv =====
`timescale 1ns / 1ps
package sf3_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NUM_AXES        = 3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_GLOBAL_STIFFNESS = 1'b0;
   localparam logic REG_USE_GLOBAL       = 1'b1;

   typedef struct packed {
      logic [NUM_AXES-1:0] dneg;
      logic                lneg;
      logic                degen;
   } sf3_flags_type;

endpackage

// ===== hdl/spring_force_3d.sv =====
`timescale 1ns / 1ps
// Hooke spring force for one spring per request.
// req channel: one spring per request; tdata carries pos0_x/y/z, pos1_x/y/z,
// rest_length and spring_stiffness, each VALUE_WIDTH bits, lowest first.
// rsp channel: one result per request, in order; tdata carries force0_x/y/z
// then force1_x/y/z; tuser bit 0 is degenerate, bit 1 is saturated.
// csr port: register 0 (address 0) is global_stiffness, register 1
// (address 4) is use_global_stiffness; write only while no request is in flight.
// Throughput: one request per cycle while the skid register is empty.
// Pipeline: the bit-per-stage square root (VALUE_WIDTH+1 stages) and the
// bit-per-stage dividers (VALUE_WIDTH+FRAC_BITS+1 stages), plus eleven
// stages of difference, squares, strain, products and saturation, lie
// between request accept and rsp_tvalid.
// Reset clears every valid bit and loads global_stiffness with 1.0 and
// use_global_stiffness with 0; no request is held across reset.
// Back-pressure: when rsp_tready is low the result holds in the output
// register and one more result lands in a skid register; the pipeline then
// freezes and req_tready drops until the skid register drains.
module spring_force_3d
   import sf3_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z, rest_length, spring_stiffness
   input  logic [8*VALUE_WIDTH-1:0]        req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // force0_x, force0_y, force0_z, force1_x, force1_y, force1_z
   output logic [6*VALUE_WIDTH-1:0]        rsp_tdata,
   // degenerate, saturated
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]           csr_paddr,
   input  logic [CSR_DATA_W-1:0]           csr_pwdata,
   output logic [CSR_DATA_W-1:0]           csr_prdata,
   output logic                            csr_pready
);

   localparam int W   = VALUE_WIDTH;
   localparam int LW  = W + 1;
   localparam int SW  = 2 * LW;
   localparam int QW  = LW + FRAC_BITS;
   localparam int UW  = FRAC_BITS + 1;
   localparam int DW  = 2 * NUM_AXES * W;
   localparam int POS1_BASE = NUM_AXES * W;
   localparam int REST_BASE = 2 * NUM_AXES * W;
   localparam int STIF_BASE = REST_BASE + W;
   localparam logic [CSR_DATA_W-1:0] STIFF_RESET = CSR_DATA_W'(64'd1 << FRAC_BITS);

   typedef struct packed {
      logic [NUM_AXES-1:0][LW-1:0] dmag;
      logic [NUM_AXES-1:0]         dneg;
      logic [W-1:0]                rest;
      logic [W-1:0]                k;
   } sq_side_type;

   typedef struct packed {
      sf3_flags_type  flags;
      logic [W-1:0]   k;
   } dv_side_type;

   logic adv;

   // configuration registers
   logic [CSR_DATA_W-1:0] global_stiffness_ff;
   logic                  use_global_ff;
   logic                  csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         global_stiffness_ff <= STIFF_RESET;
         use_global_ff       <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_GLOBAL_STIFFNESS: global_stiffness_ff <= csr_pwdata;
            REG_USE_GLOBAL:       use_global_ff       <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_GLOBAL_STIFFNESS: csr_prdata = global_stiffness_ff;
         REG_USE_GLOBAL:       csr_prdata = CSR_DATA_W'(use_global_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign req_tready = adv;

   // stage 1: coordinate differences, stiffness select
   logic                           s1_valid_ff;
   logic [NUM_AXES-1:0][W:0]       s1_d_ff;
   logic [NUM_AXES-1:0][W:0]       d_in;
   logic [W-1:0]                   s1_rest_ff;
   logic [W-1:0]                   s1_k_ff;
   logic [W-1:0]                   k_in;

   always_comb begin
      logic [W-1:0] a;
      logic [W-1:0] b;
      for (int c = 0; c < NUM_AXES; c++) begin
         a       = req_tdata[c*W +: W];
         b       = req_tdata[POS1_BASE + c*W +: W];
         d_in[c] = {a[W-1], a} - {b[W-1], b};
      end
   end

   assign k_in = use_global_ff ? W'(global_stiffness_ff) : req_tdata[STIF_BASE +: W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_d_ff    <= d_in;
         s1_rest_ff <= req_tdata[REST_BASE +: W];
         s1_k_ff    <= k_in;
      end
   end

   // stage 2: magnitude and sign
   logic                           s2_valid_ff;
   logic [NUM_AXES-1:0][LW-1:0]    s2_dmag_ff;
   logic [NUM_AXES-1:0][LW-1:0]    dmag_in;
   logic [NUM_AXES-1:0]            s2_dneg_ff;
   logic [NUM_AXES-1:0]            dneg_in;
   logic [W-1:0]                   s2_rest_ff;
   logic [W-1:0]                   s2_k_ff;

   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         dneg_in[c] = s1_d_ff[c][W];
         dmag_in[c] = s1_d_ff[c][W] ? LW'(-s1_d_ff[c]) : LW'(s1_d_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_dmag_ff <= dmag_in;
         s2_dneg_ff <= dneg_in;
         s2_rest_ff <= s1_rest_ff;
         s2_k_ff    <= s1_k_ff;
      end
   end

   // stage 3: squares
   logic                           s3_valid_ff;
   logic [NUM_AXES-1:0][SW-1:0]    s3_sq_ff;
   logic [NUM_AXES-1:0][SW-1:0]    sq_in;
   logic [NUM_AXES-1:0][LW-1:0]    s3_dmag_ff;
   logic [NUM_AXES-1:0]            s3_dneg_ff;
   logic [W-1:0]                   s3_rest_ff;
   logic [W-1:0]                   s3_k_ff;

   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         sq_in[c] = SW'(s2_dmag_ff[c]) * SW'(s2_dmag_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sq_ff   <= sq_in;
         s3_dmag_ff <= s2_dmag_ff;
         s3_dneg_ff <= s2_dneg_ff;
         s3_rest_ff <= s2_rest_ff;
         s3_k_ff    <= s2_k_ff;
      end
   end

   // stage 4: sum of squares
   logic          s4_valid_ff;
   logic [SW-1:0] s4_sum_ff;
   sq_side_type   s4_side_ff;
   sq_side_type   side4_in;

   assign side4_in.dmag = s3_dmag_ff;
   assign side4_in.dneg = s3_dneg_ff;
   assign side4_in.rest = s3_rest_ff;
   assign side4_in.k    = s3_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sum_ff  <= s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];
         s4_side_ff <= side4_in;
      end
   end

   // length
   logic                          sq_valid;
   logic [LW-1:0]                 sq_root;
   logic [$bits(sq_side_type)-1:0] sq_side_bits;
   sq_side_type                   sq_side;

   sf3_sqrt #(
      .IN_W   (SW),
      .ROOT_W (LW),
      .SIDE_W ($bits(sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s4_valid_ff),
      .in_rad    (s4_sum_ff),
      .in_side   (s4_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );

   assign sq_side = sq_side_bits;

   // strain numerator and degenerate check
   logic                           p_valid_ff;
   logic [LW-1:0]                  p_diff_ff;
   logic [LW-1:0]                  p_len_ff;
   logic [LW-1:0]                  p_rest_ff;
   logic [NUM_AXES-1:0][LW-1:0]    p_dmag_ff;
   dv_side_type                    p_side_ff;
   dv_side_type                    p_side_in;
   logic [LW-1:0]                  rest_x;
   logic                           lneg;
   logic [LW-1:0]                  diff_in;

   assign rest_x  = LW'(sq_side.rest);
   assign lneg    = sq_root < rest_x;
   assign diff_in = lneg ? (rest_x - sq_root) : (sq_root - rest_x);

   assign p_side_in.flags.dneg  = sq_side.dneg;
   assign p_side_in.flags.lneg  = lneg;
   assign p_side_in.flags.degen = (sq_root == '0) || (sq_side.rest == '0);
   assign p_side_in.k           = sq_side.k;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_diff_ff <= diff_in;
         p_len_ff  <= sq_root;
         p_rest_ff <= rest_x;
         p_dmag_ff <= sq_side.dmag;
         p_side_ff <= p_side_in;
      end
   end

   // strain and direction quotients
   logic [NUM_AXES:0][QW-1:0]     dv_num;
   logic [NUM_AXES:0][LW-1:0]     dv_den;
   logic                          dv_valid;
   logic [NUM_AXES:0][QW-1:0]     dv_quo;
   logic [$bits(dv_side_type)-1:0] dv_side_bits;
   dv_side_type                   dv_side;
   logic [NUM_AXES-1:0][UW-1:0]   dir_u;

   always_comb begin
      dv_num[0] = {p_diff_ff, {FRAC_BITS{1'b0}}};
      dv_den[0] = p_rest_ff;
      for (int c = 0; c < NUM_AXES; c++) begin
         dv_num[c+1] = {p_dmag_ff[c], {FRAC_BITS{1'b0}}};
         dv_den[c+1] = p_len_ff;
      end
   end

   sf3_div #(
      .LANES  (NUM_AXES + 1),
      .NUM_W  (QW),
      .DEN_W  (LW),
      .SIDE_W ($bits(dv_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p_valid_ff),
      .in_num    (dv_num),
      .in_den    (dv_den),
      .in_side   (p_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_bits;

   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         dir_u[c] = dv_quo[c+1][UW-1:0];
      end
   end

   // force products and saturation
   logic            f_valid;
   logic [DW-1:0]   f_data;
   logic [1:0]      f_user;

   sf3_force #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_force (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dv_valid),
      .in_q      (dv_quo[0]),
      .in_u      (dir_u),
      .in_k      (dv_side.k),
      .in_flags  (dv_side.flags),
      .out_valid (f_valid),
      .out_data  (f_data),
      .out_user  (f_user)
   );

   // output register and skid
   logic          out_valid_ff;
   logic [DW-1:0] out_data_ff;
   logic [1:0]    out_user_ff;
   logic          skid_valid_ff;
   logic [DW-1:0] skid_data_ff;
   logic [1:0]    skid_user_ff;
   logic          load_out;
   logic          load_skid;

   assign adv       = !skid_valid_ff;
   assign load_out  = adv && f_valid && (!out_valid_ff || rsp_tready);
   assign load_skid = adv && f_valid && out_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         if (load_skid) begin
            skid_valid_ff <= 1'b1;
         end else if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= f_data;
         out_user_ff <= f_user;
      end else if (!adv && rsp_tready) begin
         out_data_ff <= skid_data_ff;
         out_user_ff <= skid_user_ff;
      end
      if (load_skid) begin
         skid_data_ff <= f_data;
         skid_user_ff <= f_user;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== hdl/sf3_sqrt.sv =====
`timescale 1ns / 1ps
module sf3_sqrt
   import sf3_pkg::*;
#(
   parameter int IN_W   = 66,
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int TW = IN_W + 1;

   logic              valid_ff [ROOT_W];
   logic [IN_W-1:0]   rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   genvar i;
   for (i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int B = ROOT_W - 1 - i;
      logic              src_valid;
      logic [IN_W-1:0]   src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [SIDE_W-1:0] src_side;
      logic [TW-1:0]     trial;
      logic              take;
      logic [IN_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rad;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_root  = root_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      assign trial   = (TW'(src_root) << (B + 1)) + (TW'(1) << (2 * B));
      assign take    = {1'b0, src_rem} >= trial;
      assign rem_in  = take ? IN_W'({1'b0, src_rem} - trial) : src_rem;
      assign root_in = take ? (src_root | (ROOT_W'(1) << B)) : src_root;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== hdl/sf3_div.sv =====
`timescale 1ns / 1ps
module sf3_div
   import sf3_pkg::*;
#(
   parameter int LANES  = 4,
   parameter int NUM_W  = 49,
   parameter int DEN_W  = 33,
   parameter int SIDE_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [LANES-1:0][DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][NUM_W-1:0] out_quo,
   output logic [SIDE_W-1:0]           out_side
);

   logic                        valid_ff [NUM_W];
   logic [LANES-1:0][NUM_W-1:0] num_ff   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0] rem_ff   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff   [NUM_W];
   logic [SIDE_W-1:0]           side_ff  [NUM_W];

   genvar i, j;
   for (i = 0; i < NUM_W; i++) begin : g_stage
      logic                        src_valid;
      logic [LANES-1:0][NUM_W-1:0] src_num;
      logic [LANES-1:0][DEN_W-1:0] src_rem;
      logic [LANES-1:0][DEN_W-1:0] src_den;
      logic [SIDE_W-1:0]           src_side;
      logic [LANES-1:0][NUM_W-1:0] num_in;
      logic [LANES-1:0][DEN_W-1:0] rem_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_num   = in_num;
         assign src_rem   = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_num   = num_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_den   = den_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      for (j = 0; j < LANES; j++) begin : g_lane
         logic [DEN_W:0] shifted;
         logic           take;
         assign shifted   = {src_rem[j], src_num[j][NUM_W-1]};
         assign take      = shifted >= {1'b0, src_den[j]};
         assign rem_in[j] = take ? DEN_W'(shifted - {1'b0, src_den[j]}) : DEN_W'(shifted);
         assign num_in[j] = {src_num[j][NUM_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i]  <= num_in;
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= src_den;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== hdl/sf3_force.sv =====
`timescale 1ns / 1ps
module sf3_force
   import sf3_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [VALUE_WIDTH+FRAC_BITS:0]           in_q,
   input  logic [NUM_AXES-1:0][FRAC_BITS:0]         in_u,
   input  logic [VALUE_WIDTH-1:0]                   in_k,
   input  sf3_flags_type                            in_flags,
   output logic                                     out_valid,
   output logic [2*NUM_AXES*VALUE_WIDTH-1:0]        out_data,
   output logic [1:0]                               out_user
);

   localparam int W    = VALUE_WIDTH;
   localparam int QW   = W + 1 + FRAC_BITS;
   localparam int UW   = FRAC_BITS + 1;
   localparam int QLO  = (QW + 1) / 2;
   localparam int QHI  = QW - QLO;
   localparam int KQW  = W + QW;
   localparam int CW   = W;
   localparam int NCH  = (KQW + CW - 1) / CW;
   localparam int PPW  = CW + UW;
   localparam int ACW  = NCH * CW + UW;
   localparam int MW   = KQW + UW - 2 * FRAC_BITS;
   localparam int DW   = 2 * NUM_AXES * W;

   localparam logic [MW-1:0] LIM_POS = MW'({1'b0, {(W-1){1'b1}}});
   localparam logic [MW-1:0] LIM_NEG = MW'({1'b1, {(W-1){1'b0}}});

   function automatic logic [W:0] clip(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] lim;
      logic [W-1:0]  v;
      logic          s;
      lim = neg ? LIM_NEG : LIM_POS;
      if (mag > lim) begin
         v = lim[W-1:0];
         s = 1'b1;
      end else begin
         v = mag[W-1:0];
         s = 1'b0;
      end
      if (neg) begin
         v = -v;
      end
      return {s, v};
   endfunction

   // stage 1: k * q in two halves
   logic                              s1_valid_ff;
   logic [W+QLO-1:0]                  s1_kq_lo_ff;
   logic [W+QHI-1:0]                  s1_kq_hi_ff;
   logic [NUM_AXES-1:0][UW-1:0]       s1_u_ff;
   sf3_flags_type                     s1_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kq_lo_ff <= (W+QLO)'(in_k) * (W+QLO)'(in_q[QLO-1:0]);
         s1_kq_hi_ff <= (W+QHI)'(in_k) * (W+QHI)'(in_q[QW-1:QLO]);
         s1_u_ff     <= in_u;
         s1_flags_ff <= in_flags;
      end
   end

   // stage 2: combine halves
   logic                              s2_valid_ff;
   logic [NCH*CW-1:0]                 s2_kq_ff;
   logic [NUM_AXES-1:0][UW-1:0]       s2_u_ff;
   sf3_flags_type                     s2_flags_ff;
   logic [KQW-1:0]                    kq_in;

   assign kq_in = KQW'(s1_kq_lo_ff) + (KQW'(s1_kq_hi_ff) << QLO);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_kq_ff    <= (NCH*CW)'(kq_in);
         s2_u_ff     <= s1_u_ff;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   // stage 3: partial products against each direction term
   logic                                   s3_valid_ff;
   logic [NUM_AXES-1:0][NCH-1:0][PPW-1:0]  s3_pp_ff;
   logic [NUM_AXES-1:0][NCH-1:0][PPW-1:0]  pp_in;
   sf3_flags_type                          s3_flags_ff;

   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         for (int j = 0; j < NCH; j++) begin
            pp_in[c][j] = PPW'(s2_kq_ff[j*CW +: CW]) * PPW'(s2_u_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pp_ff    <= pp_in;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   // stage 4: sum partials, drop fraction
   logic                              s4_valid_ff;
   logic [NUM_AXES-1:0][MW-1:0]       s4_mag_ff;
   logic [NUM_AXES-1:0][MW-1:0]       mag_in;
   sf3_flags_type                     s4_flags_ff;

   always_comb begin
      logic [ACW-1:0] acc;
      acc = '0;
      for (int c = 0; c < NUM_AXES; c++) begin
         acc = '0;
         for (int j = 0; j < NCH; j++) begin
            acc = acc + (ACW'(s3_pp_ff[c][j]) << (j * CW));
         end
         mag_in[c] = MW'(acc >> (2 * FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_mag_ff   <= mag_in;
         s4_flags_ff <= s3_flags_ff;
      end
   end

   // stage 5: sign and saturate
   logic            s5_valid_ff;
   logic [DW-1:0]   s5_data_ff;
   logic [1:0]      s5_user_ff;
   logic [DW-1:0]   data_in;
   logic [1:0]      user_in;

   always_comb begin
      logic       zero;
      logic       neg0;
      logic       neg1;
      logic [W:0] r0;
      logic [W:0] r1;
      logic       sat;
      data_in = '0;
      sat     = 1'b0;
      zero    = 1'b0;
      neg0    = 1'b0;
      neg1    = 1'b0;
      r0      = '0;
      r1      = '0;
      for (int c = 0; c < NUM_AXES; c++) begin
         zero = (s4_mag_ff[c] == '0);
         neg0 = !zero && (s4_flags_ff.lneg == s4_flags_ff.dneg[c]);
         neg1 = !zero && !neg0;
         r0   = clip(neg0, s4_mag_ff[c]);
         r1   = clip(neg1, s4_mag_ff[c]);
         data_in[c*W +: W]              = r0[W-1:0];
         data_in[(c+NUM_AXES)*W +: W]   = r1[W-1:0];
         sat = sat | r0[W] | r1[W];
      end
      if (s4_flags_ff.degen) begin
         data_in = '0;
         sat     = 1'b0;
      end
      user_in = {sat, s4_flags_ff.degen};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_data_ff <= data_in;
         s5_user_ff <= user_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_data_ff;
   assign out_user  = s5_user_ff;

endmodule
